// ===== hdl/motion_light_fade_timer_macros.svh =====
// Assertion macros shared by the motion light fade timer checker.
`ifndef MOTION_LIGHT_FADE_TIMER_MACROS_SVH
`define MOTION_LIGHT_FADE_TIMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MLFT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MLFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mlft_pkg.sv =====
// Types, codes and helper functions of the motion light fade timer.
package mlft_pkg;

  localparam int HoldWidth = 22;
  localparam int StepWidth = 10;
  localparam int PctWidth = 7;
  localparam int DutyWidth = 11;

  localparam logic [HoldWidth-1:0] HOLD_MAX = {HoldWidth{1'b1}};
  localparam logic [HoldWidth-1:0] HOLD_TIME_RESET = 22'd10000;
  localparam logic [StepWidth-1:0] STEP_RESET = 10'd10;
  localparam logic [PctWidth-1:0] PCT_MAX = 7'd100;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  localparam logic [1:0] REQ_NONE = 2'd0;
  localparam logic [1:0] REQ_ON = 2'd1;
  localparam logic [1:0] REQ_OFF = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic [1:0] EVENT_NONE = 2'd0;
  localparam logic [1:0] EVENT_START = 2'd1;
  localparam logic [1:0] EVENT_STOP = 2'd2;

  localparam int AddrWidth = 4;
  localparam logic [1:0] REG_HOLD_TIME = 2'd0;
  localparam logic [1:0] REG_FADE_IN_STEP = 2'd1;
  localparam logic [1:0] REG_FADE_OUT_STEP = 2'd2;

  typedef enum logic [2:0] {
    FADE_NONE = 3'b001,
    FADE_IN   = 3'b010,
    FADE_OUT  = 3'b100
  } fade_mode_t;

  typedef struct packed {
    logic                kind;
    logic                motion_level;
    logic                set_brightness;
    logic [PctWidth-1:0] new_brightness;
    logic [1:0]          light_request;
  } item_t;

  typedef struct packed {
    logic [DutyWidth-1:0] pwm_duty;
    logic                 motion_active;
    logic [1:0]           motion_event;
    logic                 light_on;
    logic [PctWidth-1:0]  brightness_now;
    logic                 fading;
  } result_t;

  // floor(p * 1024 / 100) as p * 41944 / 4096, exact for every percent up to 127.
  function automatic logic [DutyWidth-1:0] pct_to_duty(input logic [PctWidth-1:0] p);
    logic [22:0] prod;
    prod = 23'(p) * 23'd41944;
    return prod[22:12];
  endfunction

endpackage

// ===== hdl/motion_light_fade_timer.sv =====
// Motion light fade timer: motion hold timer, light commands and PWM fade ramps.
// The block takes one item per clock cycle, a tick with the sensor level or a
// light command, and returns exactly one result per item in the cycle after the
// transfer. The whole update is one pass of counter and compare logic between the
// state registers and the result register; the result register holds a result
// until it is taken, and item_ready stays high whenever that register is empty or
// is being emptied in the same cycle. Registers sit on an APB port at byte
// addresses 0 (hold time), 4 (fade-in step delay) and 8 (fade-out step delay).
module motion_light_fade_timer (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_ready,
  input  mlft_pkg::item_t         item,
  output logic                    result_valid,
  input  logic                    result_ready,
  output mlft_pkg::result_t       result,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [mlft_pkg::AddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import mlft_pkg::*;

  logic [HoldWidth-1:0] hold_time_ms;
  logic [StepWidth-1:0] fade_in_step_ms;
  logic [StepWidth-1:0] fade_out_step_ms;

  logic                 motion_flag, motion_flag_next;
  logic [HoldWidth-1:0] hold_counter, hold_counter_next;
  fade_mode_t           fade_mode, fade_mode_next;
  logic [PctWidth-1:0]  fade_percent, fade_percent_next;
  logic [StepWidth-1:0] fade_wait, fade_wait_next;
  logic [PctWidth-1:0]  brightness_store, brightness_store_next;
  logic [DutyWidth-1:0] duty_store, duty_store_next;
  logic                 command_on, command_on_next;
  logic [1:0]           event_next;

  logic transfer_in;
  logic write_en;
  logic [1:0] reg_index;

  assign pready = 1'b1;
  assign reg_index = paddr[AddrWidth-1:2];
  assign write_en = psel && penable && pwrite && pready;
  assign item_ready = !result_valid || result_ready;
  assign transfer_in = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time_ms <= HOLD_TIME_RESET;
      fade_in_step_ms <= STEP_RESET;
      fade_out_step_ms <= STEP_RESET;
    end else if (write_en) begin
      unique case (reg_index)
        REG_HOLD_TIME:     hold_time_ms <= pwdata[HoldWidth-1:0];
        REG_FADE_IN_STEP:  fade_in_step_ms <= pwdata[StepWidth-1:0];
        REG_FADE_OUT_STEP: fade_out_step_ms <= pwdata[StepWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_HOLD_TIME:     prdata = 32'(hold_time_ms);
      REG_FADE_IN_STEP:  prdata = 32'(fade_in_step_ms);
      REG_FADE_OUT_STEP: prdata = 32'(fade_out_step_ms);
      default:           prdata = 32'd0;
    endcase
  end

  always_comb begin
    logic [StepWidth-1:0] wait_dec;
    logic [HoldWidth-1:0] hold_inc;
    fade_mode_t           start_mode;
    logic                 start_fade;
    wait_dec = (fade_wait != '0) ? fade_wait - 10'd1 : fade_wait;
    hold_inc = (hold_counter < HOLD_MAX) ? hold_counter + 22'd1 : hold_counter;
    motion_flag_next = motion_flag;
    hold_counter_next = hold_counter;
    fade_mode_next = fade_mode;
    fade_percent_next = fade_percent;
    fade_wait_next = fade_wait;
    brightness_store_next = brightness_store;
    duty_store_next = duty_store;
    command_on_next = command_on;
    event_next = EVENT_NONE;
    start_fade = 1'b0;
    start_mode = FADE_IN;

    if (item.kind == KIND_TICK) begin
      if (fade_mode != FADE_NONE) begin
        fade_wait_next = wait_dec;
        if (wait_dec == '0) begin
          if (fade_mode == FADE_IN) begin
            if (fade_percent >= brightness_store) begin
              fade_mode_next = FADE_NONE;
            end else begin
              fade_percent_next = fade_percent + 7'd1;
              duty_store_next = pct_to_duty(fade_percent + 7'd1);
              fade_wait_next = fade_in_step_ms;
            end
          end else begin
            if (fade_percent == '0) begin
              fade_mode_next = FADE_NONE;
            end else begin
              fade_percent_next = fade_percent - 7'd1;
              duty_store_next = pct_to_duty(fade_percent - 7'd1);
              fade_wait_next = fade_out_step_ms;
            end
          end
        end
      end
      if (!motion_flag) begin
        if (item.motion_level) begin
          motion_flag_next = 1'b1;
          hold_counter_next = '0;
          event_next = EVENT_START;
          start_fade = 1'b1;
          start_mode = FADE_IN;
        end
      end else begin
        hold_counter_next = hold_inc;
        if (hold_inc > hold_time_ms) begin
          if (!item.motion_level) begin
            motion_flag_next = 1'b0;
            event_next = EVENT_STOP;
            start_fade = 1'b1;
            start_mode = FADE_OUT;
          end else begin
            hold_counter_next = '0;
          end
        end
      end
    end else begin
      if (item.set_brightness) begin
        brightness_store_next = (item.new_brightness > PCT_MAX) ? PCT_MAX
                                                                : item.new_brightness;
      end
      command_on_next = (item.light_request == REQ_ON);
      if (item.light_request == REQ_ON) begin
        start_fade = 1'b1;
        start_mode = FADE_IN;
      end else if (item.light_request == REQ_OFF) begin
        start_fade = 1'b1;
        start_mode = FADE_OUT;
      end
    end

    if (start_fade) begin
      fade_mode_next = start_mode;
      if (start_mode == FADE_IN) begin
        fade_percent_next = '0;
        duty_store_next = '0;
        fade_wait_next = fade_in_step_ms;
      end else begin
        fade_percent_next = brightness_store_next;
        duty_store_next = pct_to_duty(brightness_store_next);
        fade_wait_next = fade_out_step_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      motion_flag <= 1'b0;
      hold_counter <= '0;
      fade_mode <= FADE_NONE;
      fade_percent <= '0;
      fade_wait <= '0;
      brightness_store <= PCT_MAX;
      duty_store <= '0;
      command_on <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (transfer_in) begin
        motion_flag <= motion_flag_next;
        hold_counter <= hold_counter_next;
        fade_mode <= fade_mode_next;
        fade_percent <= fade_percent_next;
        fade_wait <= fade_wait_next;
        brightness_store <= brightness_store_next;
        duty_store <= duty_store_next;
        command_on <= command_on_next;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (transfer_in) begin
      result.pwm_duty <= duty_store_next;
      result.motion_active <= motion_flag_next;
      result.motion_event <= event_next;
      result.light_on <= motion_flag_next || command_on_next;
      result.brightness_now <= brightness_store_next;
      result.fading <= (fade_mode_next != FADE_NONE);
    end
  end

endmodule

// ===== hdl/mlft_checker.sv =====
// Port-level assertions for the motion light fade timer and their bind.
`include "motion_light_fade_timer_macros.svh"

module mlft_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input mlft_pkg::result_t result,
  input logic              result_valid,
  input logic              result_ready
);
  import mlft_pkg::*;

  `MLFT_ASSERT_NEXT(a_result_holds, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")
  `MLFT_ASSERT_SAME(a_ready_when_empty, clk, rst, !result_valid, item_ready, "input stalled while the result register is empty")
  `MLFT_ASSERT_NEXT(a_result_follows, clk, rst, item_valid && item_ready, result_valid, "no result after an input transfer")
  `MLFT_ASSERT_SAME(a_event_fades, clk, rst, result_valid && (result.motion_event != EVENT_NONE), result.fading && (result.motion_active == (result.motion_event == EVENT_START)), "motion event without a matching fade")

endmodule

bind motion_light_fade_timer mlft_checker u_mlft_checker (.*);
